[hw/rtl/stereo_fractional_allpass_unit_assert.svh]
// Assertion macros shared by the allpass unit RTL.
`ifndef STEREO_FRACTIONAL_ALLPASS_UNIT_ASSERT_SVH
`define STEREO_FRACTIONAL_ALLPASS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SFAP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfap assertion failed");
// Next-cycle implication.
`define SFAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfap assertion failed");
`else
`define SFAP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SFAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/sfap_pkg.sv]
package sfap_pkg;

    localparam int LINE_DEPTH_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int DLY_W      = 20;   // Q8 delay register width
    localparam int FRAC_W     = 8;    // fraction bits of the delay
    localparam int GAIN_W     = 16;   // Q1.15 gain
    localparam int GAIN_FRAC  = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef logic [DLY_W-1:0]         t_delay;
    typedef logic signed [GAIN_W-1:0] t_gain;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    localparam t_delay DELAY_RST     = 20'd22579;
    localparam t_delay MAX_DELAY_RST = 20'd1048064;
    localparam t_delay DELAY_ONE     = 20'd256;
    localparam t_gain  GAIN_RST      = 16'sd0;
    localparam t_gain  GAIN_LIMIT    = 16'sd32735;

    localparam t_cfg_idx CFG_DELAY     = 2'd0;
    localparam t_cfg_idx CFG_MAX_DELAY = 2'd1;
    localparam t_cfg_idx CFG_FEEDBACK  = 2'd2;

    // Per-step strobes from the sequencer to each channel lane.
    typedef struct packed {
        logic ld_x;
        logic ld_dly;
        logic ld_st;
        logic we;
        logic a_ok;
        logic b_ok;
    } t_lane_ctl;

endpackage

[hw/rtl/sfap_if.sv]
interface sfap_frame_if import sfap_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

interface sfap_result_if import sfap_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

interface sfap_cfg_if import sfap_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/sfap_ram.sv]
module sfap_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;
endmodule

[hw/rtl/sfap_addr.sv]
module sfap_addr import sfap_pkg::*; #(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF,
    localparam int AW        = $clog2(LINE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_delay            i_delay,
    input  t_delay            i_max_delay,
    input  logic [AW-1:0]     i_wp,
    output logic              o_busy,
    output logic [AW-1:0]     o_addr_a,
    output logic [AW-1:0]     o_addr_b,
    output logic [FRAC_W-1:0] o_frac
);
    localparam int SPAN   = LINE_DEPTH * (2 ** FRAC_W);
    localparam int SPAN_W = $clog2(SPAN);
    localparam int RED_LV = (DLY_W >= SPAN_W) ? (DLY_W - SPAN_W + 1) : 1;
    localparam int LV_W   = (RED_LV > 1) ? $clog2(RED_LV) : 1;
    localparam int CW     = SPAN_W + RED_LV;
    localparam int PW     = SPAN_W + 1;

    logic            r_pend;
    logic            r_run;
    logic [LV_W-1:0] r_lvl;
    t_delay          r_rem;

    t_delay            dmin;
    t_delay            dclamp;
    logic [CW-1:0]     rem_w;
    logic [CW-1:0]     sub_w;
    logic [CW-1:0]     diff_w;
    logic [SPAN_W-1:0] dred;
    logic [PW-1:0]     pos_raw;
    logic [PW-1:0]     pos;

    // Clamp to the max register, floor at one sample.
    assign dmin   = (i_delay < i_max_delay) ? i_delay : i_max_delay;
    assign dclamp = (dmin < DELAY_ONE) ? DELAY_ONE : dmin;

    // Restoring reduction modulo the line span, one multiple per cycle.
    assign rem_w  = CW'(r_rem);
    assign sub_w  = CW'(SPAN) << r_lvl;
    assign diff_w = rem_w - sub_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b1;
            r_run  <= 1'b0;
            r_lvl  <= '0;
        end else if (i_load) begin
            r_pend <= 1'b1;
            r_run  <= 1'b0;
        end else if (r_pend) begin
            r_pend <= 1'b0;
            r_run  <= 1'b1;
            r_rem  <= dclamp;
            r_lvl  <= LV_W'(RED_LV - 1);
        end else if (r_run) begin
            if (rem_w >= sub_w) begin
                r_rem <= DLY_W'(diff_w);
            end
            if (r_lvl == '0) begin
                r_run <= 1'b0;
            end else begin
                r_lvl <= r_lvl - LV_W'(1);
            end
        end
    end

    assign o_busy = r_pend | r_run;
    assign dred   = SPAN_W'(r_rem);

    // Read position behind the write pointer, wrapped into the span.
    assign pos_raw = {1'b0, i_wp, {FRAC_W{1'b0}}} + PW'(SPAN) - PW'(dred);
    assign pos     = (pos_raw >= PW'(SPAN)) ? (pos_raw - PW'(SPAN)) : pos_raw;

    assign o_addr_a = pos[AW+FRAC_W-1:FRAC_W];
    assign o_frac   = pos[FRAC_W-1:0];
    assign o_addr_b = (o_addr_a == AW'(LINE_DEPTH - 1)) ? '0 : (o_addr_a + AW'(1));
endmodule

[hw/rtl/sfap_lane.sv]
module sfap_lane import sfap_pkg::*; #(
    parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int AW         = $clog2(LINE_DEPTH)
) (
    input  logic                          i_clk,
    input  t_lane_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  t_gain                         i_gain,
    input  logic [FRAC_W-1:0]             i_frac,
    input  logic [AW-1:0]                 i_raddr_a,
    input  logic [AW-1:0]                 i_raddr_b,
    input  logic [AW-1:0]                 i_waddr,
    output logic signed [SAMPLE_BITS-1:0] o_y
);
    localparam int SB = SAMPLE_BITS;
    localparam int IW = SB + FRAC_W + 2;   // interpolation product
    localparam int MW = SB + GAIN_W;       // gain product

    function automatic logic signed [SB-1:0] sat(input logic signed [SB+1:0] v);
        logic [2:0] top;
        top = v[SB+1:SB-1];
        if (top == 3'b000 || top == 3'b111) begin
            return v[SB-1:0];
        end
        return {v[SB+1], {(SB-1){~v[SB+1]}}};
    endfunction

    logic signed [SB-1:0] r_x;
    logic signed [SB-1:0] r_dly;
    logic signed [SB-1:0] r_st;

    logic [SB-1:0]        rd_a;
    logic [SB-1:0]        rd_b;
    logic signed [SB-1:0] a_s;
    logic signed [SB-1:0] b_s;
    logic signed [SB:0]   diff;
    logic signed [IW-1:0] ip;
    logic signed [IW-1:0] ip_r;
    logic signed [SB+1:0] dly_w;
    logic signed [SB-1:0] n_dly;
    logic signed [MW-1:0] p1;
    logic signed [MW-1:0] p1_r;
    logic signed [SB+1:0] st_w;
    logic signed [SB-1:0] n_st;
    logic signed [MW-1:0] p2;
    logic signed [MW-1:0] p2_r;
    logic signed [SB+1:0] y_w;

    sfap_ram #(
        .WIDTH (SB),
        .DEPTH (LINE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_ctl.we),
        .i_waddr   (i_waddr),
        .i_wdata   (r_st),
        .i_raddr_a (i_raddr_a),
        .i_raddr_b (i_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Entries never written since reset read as zero.
    assign a_s = i_ctl.a_ok ? $signed(rd_a) : '0;
    assign b_s = i_ctl.b_ok ? $signed(rd_b) : '0;

    // Linear interpolation, halves round up.
    assign diff  = (SB+1)'(b_s) - (SB+1)'(a_s);
    assign ip    = IW'(diff) * IW'($signed({1'b0, i_frac}));
    assign ip_r  = ip + IW'(2 ** (FRAC_W - 1));
    assign dly_w = (SB+2)'(a_s) + ip_r[IW-1:FRAC_W];
    assign n_dly = dly_w[SB-1:0];

    // state = x + g*delayed
    assign p1   = MW'(i_gain) * MW'(r_dly);
    assign p1_r = p1 + MW'(2 ** (GAIN_FRAC - 1));
    assign st_w = (SB+2)'(r_x) + (SB+2)'($signed(p1_r[MW-1:GAIN_FRAC]));
    assign n_st = sat(st_w);

    // y = delayed - g*state
    assign p2   = MW'(i_gain) * MW'(r_st);
    assign p2_r = p2 + MW'(2 ** (GAIN_FRAC - 1));
    assign y_w  = (SB+2)'(r_dly) - (SB+2)'($signed(p2_r[MW-1:GAIN_FRAC]));
    assign o_y  = sat(y_w);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_x) begin
            r_x <= i_x;
        end
        if (i_ctl.ld_dly) begin
            r_dly <= n_dly;
        end
        if (i_ctl.ld_st) begin
            r_st <= n_st;
        end
    end
endmodule

[hw/rtl/stereo_fractional_allpass_unit.sv]
// Channel     Dir  Handshake      Payload
// i_frame     in   valid/ready    sample_left, sample_right (signed SAMPLE_BITS)
// o_result    out  valid/ready    out_left, out_right (signed SAMPLE_BITS, saturated)
// i_cfg       in   valid/ready    index (0 delay, 1 max delay, 2 feedback), data
//
// Per item, in order: RAM read, interpolation, state and output steps, the last two
// each built on one gain multiply; the next item is accepted as a result is loaded.
// Reset is synchronous, active low. Delay lines read as zero until written (fill count).
// After reset and after every configuration write, i_frame.ready stays low for the
// delay wrap reduction.
// A result not taken holds the sequencer at its output step and i_frame.ready low.
`include "stereo_fractional_allpass_unit_assert.svh"

module stereo_fractional_allpass_unit import sfap_pkg::*; #(
    parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sfap_frame_if.sink     i_frame,
    sfap_result_if.source  o_result,
    sfap_cfg_if.sink       i_cfg
);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int FW = $clog2(LINE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_INT,
        S_ST,
        S_OUT
    } t_state;

    t_state                        r_fsm;
    t_delay                        r_delay;
    t_delay                        r_max_delay;
    t_gain                         r_gain;
    logic [AW-1:0]                 r_wp;
    logic [AW-1:0]                 r_wa;
    logic [AW-1:0]                 r_ra;
    logic [AW-1:0]                 r_rb;
    logic [FRAC_W-1:0]             r_frac;
    logic [FW-1:0]                 r_fill;
    logic                          r_a_ok;
    logic                          r_b_ok;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_l;
    logic signed [SAMPLE_BITS-1:0] r_out_r;

    logic              frame_acc;
    logic              cfg_acc;
    logic              out_free;
    logic              red_busy;
    logic              out_load;
    logic [AW-1:0]     addr_a;
    logic [AW-1:0]     addr_b;
    logic [FRAC_W-1:0] frac;
    logic [AW-1:0]     n_wp;
    t_gain             n_gain;
    t_gain             cfg_gain;
    t_lane_ctl         lane_ctl;

    logic signed [SAMPLE_BITS-1:0] y_l;
    logic signed [SAMPLE_BITS-1:0] y_r;

    // Handshakes
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_out_valid || o_result.ready;
    assign out_load    = (r_fsm == S_OUT) && out_free;
    // Take a new item from idle, or as the current one moves into the output register.
    assign i_frame.ready = !red_busy && ((r_fsm == S_IDLE) || out_load);
    assign frame_acc     = i_frame.valid && i_frame.ready;

    assign o_result.valid     = r_out_valid;
    assign o_result.out_left  = r_out_l;
    assign o_result.out_right = r_out_r;

    // Clamp the gain to plus or minus 0.999 as it is written.
    assign cfg_gain = $signed(i_cfg.data[GAIN_W-1:0]);
    assign n_gain   = (cfg_gain > GAIN_LIMIT)  ? GAIN_LIMIT :
                      (cfg_gain < -GAIN_LIMIT) ? -GAIN_LIMIT : cfg_gain;

    assign n_wp = (r_wp == AW'(LINE_DEPTH - 1)) ? '0 : (r_wp + AW'(1));

    sfap_addr #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (cfg_acc),
        .i_delay     (r_delay),
        .i_max_delay (r_max_delay),
        .i_wp        (r_wp),
        .o_busy      (red_busy),
        .o_addr_a    (addr_a),
        .o_addr_b    (addr_b),
        .o_frac      (frac)
    );

    always_comb begin
        lane_ctl        = '0;
        lane_ctl.ld_x   = frame_acc;
        lane_ctl.ld_dly = (r_fsm == S_INT);
        lane_ctl.ld_st  = (r_fsm == S_ST);
        lane_ctl.we     = out_load;
        lane_ctl.a_ok   = r_a_ok;
        lane_ctl.b_ok   = r_b_ok;
    end

    // Two channel lanes share addresses, fraction and gain.
    sfap_lane #(
        .LINE_DEPTH  (LINE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_l (
        .i_clk     (i_clk),
        .i_ctl     (lane_ctl),
        .i_x       (i_frame.sample_left),
        .i_gain    (r_gain),
        .i_frac    (r_frac),
        .i_raddr_a (r_ra),
        .i_raddr_b (r_rb),
        .i_waddr   (r_wa),
        .o_y       (y_l)
    );

    sfap_lane #(
        .LINE_DEPTH  (LINE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_r (
        .i_clk     (i_clk),
        .i_ctl     (lane_ctl),
        .i_x       (i_frame.sample_right),
        .i_gain    (r_gain),
        .i_frac    (r_frac),
        .i_raddr_a (r_ra),
        .i_raddr_b (r_rb),
        .i_waddr   (r_wa),
        .o_y       (y_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_delay     <= DELAY_RST;
            r_max_delay <= MAX_DELAY_RST;
            r_gain      <= GAIN_RST;
            r_wp        <= '0;
            r_fill      <= '0;
            r_a_ok      <= 1'b0;
            r_b_ok      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                case (i_cfg.index)
                    CFG_DELAY:     r_delay     <= i_cfg.data;
                    CFG_MAX_DELAY: r_max_delay <= i_cfg.data;
                    CFG_FEEDBACK:  r_gain      <= n_gain;
                    default:       ;  // drop writes past the register list
                endcase
            end

            // Capture read taps and write slot, advance the pointer at accept.
            if (frame_acc) begin
                r_ra   <= addr_a;
                r_rb   <= addr_b;
                r_frac <= frac;
                r_wa   <= r_wp;
                r_wp   <= n_wp;
            end

            case (r_fsm)
                S_IDLE: begin
                    if (frame_acc) begin
                        r_fsm <= S_RD;
                    end
                end
                S_RD: begin
                    // Flag taps that the fill count says were never written.
                    r_a_ok <= (FW'(r_ra) < r_fill);
                    r_b_ok <= (FW'(r_rb) < r_fill);
                    r_fsm  <= S_INT;
                end
                S_INT: r_fsm <= S_ST;
                S_ST:  r_fsm <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_fsm <= frame_acc ? S_RD : S_IDLE;
                    end
                end
                default: r_fsm <= S_IDLE;
            endcase

            // Merge the lanes into the result register; the state is written now.
            if (out_load) begin
                r_out_l     <= y_l;
                r_out_r     <= y_r;
                r_out_valid <= 1'b1;
                if (r_fill != FW'(LINE_DEPTH)) begin
                    r_fill <= r_fill + FW'(1);
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `SFAP_ASSERT_NEXT(a_acc_to_read, i_clk, i_rst_n, frame_acc, r_fsm == S_RD)
    `SFAP_ASSERT_NOW(a_reduce_blocks, i_clk, i_rst_n, red_busy, !i_frame.ready)
    `SFAP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, (r_fsm == S_OUT) && !out_free, (r_fsm == S_OUT) && r_out_valid)
    `SFAP_ASSERT_NEXT(a_write_slot, i_clk, i_rst_n, frame_acc, r_wa == $past(r_wp))

endmodule

[tb/testbench.sv]
module testbench;
    import sfap_pkg::*;

    localparam int    DEPTH    = LINE_DEPTH_DEF;
    localparam int    SB       = SAMPLE_BITS_DEF;
    localparam longint SPAN    = longint'(DEPTH) * 256;
    localparam int    PHASES   = 14;
    localparam int    PHASE_LEN = 100;

    // Index 3 decodes to no register; a write there must leave the setup alone.
    localparam t_cfg_idx CFG_SPARE = 2'd3;

    typedef logic signed [SB-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } frame_t;

    typedef struct {
        bit     on;
        frame_t val;
    } typed_frame_t;

    typedef enum bit {ROW_FRAME, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e       kind;
        t_cfg_idx        idx;
        logic [CFG_DATA_W-1:0] data;
        frame_t          stim;
        bit              typed;
        frame_t          want;
    } plan_row_t;

    logic i_clk;
    logic i_rst_n;

    sfap_frame_if  frame_ch();
    sfap_result_if result_ch();
    sfap_cfg_if    cfg_ch();

    stereo_fractional_allpass_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // Clock: period of 2 time units.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Hard stop for a hung handshake.
    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Allpass predictor: its own copy of the registers, both delay lines and
    // the shared write pointer.
    // ------------------------------------------------------------------
    t_delay          dly_reg   = DELAY_RST;
    t_delay          dly_max   = MAX_DELAY_RST;
    t_gain           gain_reg  = GAIN_RST;
    sample_t         line_left  [DEPTH] = '{default: '0};
    sample_t         line_right [DEPTH] = '{default: '0};
    logic [11:0]     wr_ptr    = '0;

    frame_t          expected_out_q[$];
    typed_frame_t    typed_out_q[$];
    int              mismatch_cnt = 0;

    // Idle behavior of each side, reshuffled at every phase.
    bit              src_steady  = 1'b0;
    bit              sink_steady = 1'b0;

    // floor((v + half) / 2^s): halves round toward plus infinity.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip_sample(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (SB - 1)) - 1;
        lo = -(longint'(1) << (SB - 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // One channel: interpolate the tap, then feedback state and output.
    function automatic void allpass_tap(input longint x, input longint tap_a,
                                        input longint tap_b, input longint g,
                                        input int frac, output longint st,
                                        output longint y);
        longint dl;
        dl = tap_a + round_shift((tap_b - tap_a) * frac, FRAC_W);
        st = clip_sample(x + round_shift(g * dl, GAIN_FRAC));
        y  = clip_sample(dl - round_shift(g * st, GAIN_FRAC));
    endfunction

    task automatic allpass_predict(input sample_t xl, input sample_t xr,
                                   output frame_t y);
        longint d;
        longint pos;
        longint g;
        longint st;
        longint yv;
        int     a_idx;
        int     b_idx;
        int     frac;
        // Smaller register wins, floor of one sample, wrap into the line.
        d = (dly_reg < dly_max) ? longint'(dly_reg) : longint'(dly_max);
        if (d < longint'(DELAY_ONE))
            d = DELAY_ONE;
        d = d % SPAN;
        pos = longint'(wr_ptr) * 256 + SPAN - d;
        if (pos >= SPAN)
            pos -= SPAN;
        a_idx = int'(pos >> FRAC_W);
        frac  = int'(pos & 255);
        b_idx = (a_idx + 1) % DEPTH;

        g = longint'(gain_reg);
        if (g > longint'(GAIN_LIMIT))
            g = GAIN_LIMIT;
        if (g < -longint'(GAIN_LIMIT))
            g = -longint'(GAIN_LIMIT);

        allpass_tap(longint'(xl), longint'(line_left[a_idx]), longint'(line_left[b_idx]),
                    g, frac, st, yv);
        line_left[wr_ptr] = sample_t'(st);
        y.left = sample_t'(yv);
        allpass_tap(longint'(xr), longint'(line_right[a_idx]), longint'(line_right[b_idx]),
                    g, frac, st, yv);
        line_right[wr_ptr] = sample_t'(st);
        y.right = sample_t'(yv);
        wr_ptr = wr_ptr + 1'b1;
    endtask

    // Mirror every accepted register write.
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.index)
                CFG_DELAY:     dly_reg  = cfg_ch.data[DLY_W-1:0];
                CFG_MAX_DELAY: dly_max  = cfg_ch.data[DLY_W-1:0];
                CFG_FEEDBACK:  gain_reg = cfg_ch.data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Predict each accepted item; a typed-in value overrides the prediction.
    always @(posedge i_clk) begin
        frame_t       pred;
        typed_frame_t t;
        if (i_rst_n && frame_ch.valid && frame_ch.ready) begin
            allpass_predict(frame_ch.sample_left, frame_ch.sample_right, pred);
            t = typed_out_q.pop_front();
            if (t.on)
                pred = t.val;
            expected_out_q.push_back(pred);
        end
    end

    task automatic log_mismatch(input string what, input sample_t want, input sample_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        frame_t want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_out_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: left %0d right %0d",
                             result_ch.out_left, result_ch.out_right);
            end else begin
                want = expected_out_q.pop_front();
                if (result_ch.out_left !== want.left)
                    log_mismatch("out_left", want.left, result_ch.out_left);
                if (result_ch.out_right !== want.right)
                    log_mismatch("out_right", want.right, result_ch.out_right);
            end
        end
    end

    // Result side: per item, wait a random time unless steady, then hold ready until taken.
    initial begin
        int w;
        result_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            w = sink_steady ? 0 : $urandom_range(0, 13);
            if (w > 0) begin
                result_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(result_ch.valid && result_ch.ready))
                @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Hold valid across back-to-back items; drop it only for a drawn gap.
    task automatic send_frame(input frame_t f, input bit typed, input frame_t want);
        int           gap;
        typed_frame_t t;
        t.on  = typed;
        t.val = want;
        typed_out_q.push_back(t);
        gap = src_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frame_ch.valid        <= 1'b1;
        frame_ch.sample_left  <= f.left;
        frame_ch.sample_right <= f.right;
        @(posedge i_clk);
        while (!frame_ch.ready)
            @(posedge i_clk);
    endtask

    // Stop sending and wait for every expected result. Wait for a clock edge first so
    // the item accepted at the last edge is already queued. Each item yields
    // exactly one result, so the block is idle once the queue is empty.
    task automatic drain();
        frame_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_out_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic sample_t draw_sample();
        case ($urandom_range(0, 7))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2, 3:    return sample_t'(int'($urandom_range(0, 4000)) - 2000);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Directed part. After reset the tap sits 88.2 samples back in empty lines,
    // so outputs are zero; with a one-sample delay and zero gain each output
    // is the previous input. Other rows go through the predictor.
    localparam int PLAN_LEN = 25;
    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_FRAME, CFG_DELAY, 0, '{24'sh7FFFFF, 24'sh800000}, 1, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{24'sh800000, 24'sh7FFFFF}, 1, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{0, -1},                    1, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{1, 24'sh555555},           1, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{24'shAAAAAA, 0},           1, '{0, 0}},
        // delay of zero: raised to one sample
        '{ROW_CFG,   CFG_DELAY, 20'd0, '{0, 0}, 0, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{24'sh7FFFFF, 24'sh800000}, 1, '{24'shAAAAAA, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{24'sh800000, 24'sh7FFFFF}, 1,
          '{24'sh7FFFFF, 24'sh800000}},
        '{ROW_FRAME, CFG_DELAY, 0, '{12345, -12345},            1,
          '{24'sh800000, 24'sh7FFFFF}},
        // most negative gain: clamped to -0.999, state saturates
        '{ROW_CFG,   CFG_FEEDBACK, 20'h08000, '{0, 0}, 0, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{24'sh7FFFFF, 24'sh7FFFFF}, 0, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{24'sh800000, 24'sh800000}, 0, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{24'sh7FFFFF, 24'sh800000}, 0, '{0, 0}},
        // delay above max: max wins at 1.17 samples; gain top clamped, upper bits junk
        '{ROW_CFG,   CFG_DELAY,     20'hFFFFF, '{0, 0}, 0, '{0, 0}},
        '{ROW_CFG,   CFG_MAX_DELAY, 20'd300,   '{0, 0}, 0, '{0, 0}},
        '{ROW_CFG,   CFG_FEEDBACK,  20'hF7FFF, '{0, 0}, 0, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{24'sh7FFFFF, 24'sh800000}, 0, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{24'sh800000, 24'sh7FFFFF}, 0, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{1000, -1},                 0, '{0, 0}},
        // max of zero: floor of one sample applies to the clamp as well
        '{ROW_CFG,   CFG_MAX_DELAY, 20'd0, '{0, 0}, 0, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{0, 0},                     0, '{0, 0}},
        // longest delay: the read position wraps almost a full line back
        '{ROW_CFG,   CFG_MAX_DELAY, 20'hFFFFF, '{0, 0}, 0, '{0, 0}},
        '{ROW_CFG,   CFG_SPARE,     20'hABCDE, '{0, 0}, 0, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{24'sh400000, 24'shC00000}, 0, '{0, 0}},
        '{ROW_FRAME, CFG_DELAY, 0, '{-1, 1},                    0, '{0, 0}}
    };

    initial begin
        frame_t      f;
        t_delay      dly;
        t_delay      dmax;
        t_gain       g;
        frame_t      none;

        none = '0;
        i_rst_n               <= 1'b0;
        frame_ch.valid        <= 1'b0;
        frame_ch.sample_left  <= '0;
        frame_ch.sample_right <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= CFG_DELAY;
        cfg_ch.data           <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; register writes only once the block is idle.
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_CFG) begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_frame(plan[i].stim, plan[i].typed, plan[i].want);
            end
        end

        // Random phases: fresh registers, fresh idle behavior, then a burst of items.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case ($urandom_range(0, 7))
                0:       dly = t_delay'($urandom_range(0, 255));
                1:       dly = DELAY_ONE;
                2:       dly = 20'hFFFFF;
                3:       dly = t_delay'($urandom);
                4:       dly = t_delay'($urandom_range(256, 64 * 256));
                default: dly = t_delay'($urandom_range(256, 12 * 256));
            endcase
            case ($urandom_range(0, 3))
                0:       dmax = t_delay'($urandom_range(0, 16 * 256));
                1:       dmax = t_delay'($urandom);
                default: dmax = 20'hFFFFF;
            endcase
            case ($urandom_range(0, 7))
                0:       g = 16'sh8000;
                1:       g = 16'sh7FFF;
                2:       g = GAIN_LIMIT;
                3:       g = -GAIN_LIMIT;
                default: g = t_gain'($urandom);
            endcase
            // Keep the final phase at the extremes of all three registers.
            if (p == PHASES - 1) begin
                dly  = 20'hFFFFF;
                dmax = 20'd256;
                g    = 16'sh8000;
            end
            write_reg(CFG_DELAY, dly);
            write_reg(CFG_MAX_DELAY, dmax);
            write_reg(CFG_FEEDBACK, {4'($urandom_range(0, 15)), g});
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);

            for (int k = 0; k < PHASE_LEN; k++) begin
                f.left  = draw_sample();
                f.right = draw_sample();
                send_frame(f, 1'b0, none);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_out_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/sfap_pkg.sv
hw/rtl/sfap_if.sv
hw/rtl/sfap_ram.sv
hw/rtl/sfap_addr.sv
hw/rtl/sfap_lane.sv
hw/rtl/stereo_fractional_allpass_unit.sv
tb/testbench.sv
